@@ sv/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for quaternion to euler conversion
// Fixed-point widths, the arctangent table and the operand bundle that
// travels through the square root pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int QUAT_W           = 16;
   localparam int PROD_W           = 34;
   localparam int RAD_W            = 58;
   localparam int ROOT_W           = 29;
   localparam int CORDIC_W         = 37;
   localparam int ANGLE_W          = 34;
   localparam int ROLL_W           = 16;
   localparam int PITCH_W          = 15;
   localparam int ATAN_LEN         = 24;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam logic signed [PROD_W-1:0]  ONE_Q28     = PROD_W'(64'sd268435456);
   localparam logic signed [ANGLE_W-1:0] PI_Q29      = ANGLE_W'(64'sd1686629713);
   localparam logic signed [ROLL_W-1:0]  PI_Q13      = 16'sd25736;
   localparam logic signed [ROLL_W-1:0]  HALF_PI_Q13 = 16'sd12868;

   typedef struct packed {
      logic signed [PROD_W-1:0] roll_y;
      logic signed [PROD_W-1:0] roll_x;
      logic signed [PROD_W-1:0] yaw_y;
      logic signed [PROD_W-1:0] yaw_x;
      logic signed [PROD_W-1:0] pitch_s;
      logic                     clamp;
      logic                     neg;
   } op_type;

   // atan(2^-i) in Q29
   function automatic logic signed [ANGLE_W-1:0] atan_q29(input logic [4:0] idx);
      logic signed [ANGLE_W-1:0] v;
      case (idx)
         5'd0:    v = ANGLE_W'(64'sd421657428);
         5'd1:    v = ANGLE_W'(64'sd248918915);
         5'd2:    v = ANGLE_W'(64'sd131521918);
         5'd3:    v = ANGLE_W'(64'sd66762579);
         5'd4:    v = ANGLE_W'(64'sd33510843);
         5'd5:    v = ANGLE_W'(64'sd16771758);
         5'd6:    v = ANGLE_W'(64'sd8387925);
         5'd7:    v = ANGLE_W'(64'sd4194219);
         5'd8:    v = ANGLE_W'(64'sd2097141);
         5'd9:    v = ANGLE_W'(64'sd1048575);
         5'd10:   v = ANGLE_W'(64'sd524288);
         5'd11:   v = ANGLE_W'(64'sd262144);
         5'd12:   v = ANGLE_W'(64'sd131072);
         5'd13:   v = ANGLE_W'(64'sd65536);
         5'd14:   v = ANGLE_W'(64'sd32768);
         5'd15:   v = ANGLE_W'(64'sd16384);
         5'd16:   v = ANGLE_W'(64'sd8192);
         5'd17:   v = ANGLE_W'(64'sd4096);
         5'd18:   v = ANGLE_W'(64'sd2048);
         5'd19:   v = ANGLE_W'(64'sd1024);
         5'd20:   v = ANGLE_W'(64'sd512);
         5'd21:   v = ANGLE_W'(64'sd256);
         5'd22:   v = ANGLE_W'(64'sd128);
         5'd23:   v = ANGLE_W'(64'sd64);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/qte_prod.sv @@
// ----------------------------------------------------------------------------
// qte_prod: product sums front end
// Four stages: component products, product sums, pitch clamp test and
// magnitude, then the radicand 1 - s*s for the pitch square root.
// ----------------------------------------------------------------------------
module qte_prod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [qte_pkg::QUAT_W-1:0]   in_w,
   input  logic signed [qte_pkg::QUAT_W-1:0]   in_x,
   input  logic signed [qte_pkg::QUAT_W-1:0]   in_y,
   input  logic signed [qte_pkg::QUAT_W-1:0]   in_z,
   output logic                                out_valid,
   output qte_pkg::op_type                     out_op,
   output logic [qte_pkg::RAD_W-1:0]           out_rad
);
   import qte_pkg::*;

   localparam int PW = 2 * QUAT_W;

   logic [3:0] v_ff;

   // stage 1
   logic signed [PW-1:0] pwx_ff, pyz_ff, pxx_ff, pyy_ff, pwz_ff, pxy_ff, pzz_ff, pwy_ff, pzx_ff;
   // stage 2
   op_type op2_ff, op2_in;
   // stage 3
   op_type op3_ff, op3_in;
   logic [ROOT_W-2:0] mag_ff, mag_in;
   // stage 4
   op_type op4_ff;
   logic [RAD_W-1:0] rad_ff, rad_in;

   logic signed [PROD_W-1:0] s_abs;
   logic [2*(ROOT_W-1)-1:0]  sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_comb begin
      op2_in         = '0;
      op2_in.roll_y  = (PROD_W'(pwx_ff) + PROD_W'(pyz_ff)) <<< 1;
      op2_in.roll_x  = ONE_Q28 - ((PROD_W'(pxx_ff) + PROD_W'(pyy_ff)) <<< 1);
      op2_in.yaw_y   = (PROD_W'(pwz_ff) + PROD_W'(pxy_ff)) <<< 1;
      op2_in.yaw_x   = ONE_Q28 - ((PROD_W'(pyy_ff) + PROD_W'(pzz_ff)) <<< 1);
      op2_in.pitch_s = (PROD_W'(pwy_ff) - PROD_W'(pzx_ff)) <<< 1;
   end

   always_comb begin
      op3_in       = op2_ff;
      op3_in.clamp = (op2_ff.pitch_s >= ONE_Q28) || (op2_ff.pitch_s <= -ONE_Q28);
      op3_in.neg   = op2_ff.pitch_s[PROD_W-1];
      s_abs        = op2_ff.pitch_s[PROD_W-1] ? -op2_ff.pitch_s : op2_ff.pitch_s;
      mag_in       = s_abs[ROOT_W-2:0];
   end

   // 2^56 - mag^2, which needs 57 bits when mag is zero
   always_comb begin
      sq     = mag_ff * mag_ff;
      rad_in = (RAD_W'(1) << (2 * (ROOT_W - 1))) - RAD_W'(sq);
   end

   always_ff @(posedge clock) begin
      pwx_ff <= in_w * in_x;
      pyz_ff <= in_y * in_z;
      pxx_ff <= in_x * in_x;
      pyy_ff <= in_y * in_y;
      pwz_ff <= in_w * in_z;
      pxy_ff <= in_x * in_y;
      pzz_ff <= in_z * in_z;
      pwy_ff <= in_w * in_y;
      pzx_ff <= in_z * in_x;
      op2_ff <= op2_in;
      op3_ff <= op3_in;
      mag_ff <= mag_in;
      op4_ff <= op3_ff;
      rad_ff <= rad_in;
   end

   assign out_valid = v_ff[3];
   assign out_op    = op4_ff;
   assign out_rad   = rad_ff;

endmodule

@@ sv/qte_sqrt.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, with the other
// operands carried alongside.
// ----------------------------------------------------------------------------
module qte_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  qte_pkg::op_type              in_op,
   input  logic [qte_pkg::RAD_W-1:0]    in_rad,
   output logic                         out_valid,
   output qte_pkg::op_type              out_op,
   output logic [qte_pkg::ROOT_W-1:0]   out_root
);
   import qte_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic               v_ff    [1:ROOT_W];
   op_type             op_ff   [1:ROOT_W];
   logic [RAD_W-1:0]   rad_ff  [1:ROOT_W];
   logic [REM_W-1:0]   rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0]  root_ff [1:ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              cur_v;
      op_type            cur_op;
      logic [RAD_W-1:0]  cur_rad;
      logic [REM_W-1:0]  cur_rem;
      logic [ROOT_W-1:0] cur_root;
      logic [REM_W-1:0]  r2, trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign cur_v    = in_valid;
         assign cur_op   = in_op;
         assign cur_rad  = in_rad;
         assign cur_rem  = '0;
         assign cur_root = '0;
      end else begin : g_next
         assign cur_v    = v_ff[k];
         assign cur_op   = op_ff[k];
         assign cur_rad  = rad_ff[k];
         assign cur_rem  = rem_ff[k];
         assign cur_root = root_ff[k];
      end

      assign r2    = {cur_rem[ROOT_W-1:0], cur_rad[RAD_W-1 -: 2]};
      assign trial = {cur_root, 2'b01};
      assign ge    = r2 >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         op_ff[k+1]   <= cur_op;
         rad_ff[k+1]  <= cur_rad << 2;
         rem_ff[k+1]  <= ge ? r2 - trial : r2;
         root_ff[k+1] <= {cur_root[ROOT_W-2:0], ge};
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_op    = op_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];

endmodule

@@ sv/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC for atan2
// Quadrant fold stage, one micro-rotation per stage, then round and
// saturate to plus or minus pi in Q3.13.
// ----------------------------------------------------------------------------
module qte_cordic #(
   parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [qte_pkg::PROD_W-1:0]   in_y,
   input  logic signed [qte_pkg::PROD_W-1:0]   in_x,
   output logic                                out_valid,
   output logic signed [qte_pkg::ROLL_W-1:0]   out_angle
);
   import qte_pkg::*;

   localparam int SH_W = ANGLE_W - 16;

   logic                        v_ff    [0:STEPS];
   logic                        zero_ff [0:STEPS];
   logic signed [CORDIC_W-1:0]  x_ff    [0:STEPS];
   logic signed [CORDIC_W-1:0]  y_ff    [0:STEPS];
   logic signed [ANGLE_W-1:0]   z_ff    [0:STEPS];

   logic signed [CORDIC_W-1:0]  ex, ey;
   logic                        vout_ff;
   logic signed [ROLL_W-1:0]    ang_ff, ang_in;
   logic signed [ANGLE_W-1:0]   rnd;
   logic signed [SH_W-1:0]      sh;

   assign ex = CORDIC_W'(in_x);
   assign ey = CORDIC_W'(in_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   // fold the left half plane by pi
   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (in_x[PROD_W-1]) begin
         x_ff[0] <= -ex;
         y_ff[0] <= -ey;
         z_ff[0] <= in_y[PROD_W-1] ? -PI_Q29 : PI_Q29;
      end else begin
         x_ff[0] <= ex;
         y_ff[0] <= ey;
         z_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      logic signed [CORDIC_W-1:0] xs, ys;
      logic signed [ANGLE_W-1:0]  at;
      logic                       pos;

      assign xs  = x_ff[k] >>> k;
      assign ys  = y_ff[k] >>> k;
      assign at  = atan_q29(5'(k));
      assign pos = !y_ff[k][CORDIC_W-1] && (y_ff[k] != '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         zero_ff[k+1] <= zero_ff[k];
         if (pos) begin
            x_ff[k+1] <= x_ff[k] + ys;
            y_ff[k+1] <= y_ff[k] - xs;
            z_ff[k+1] <= z_ff[k] + at;
         end else begin
            x_ff[k+1] <= x_ff[k] - ys;
            y_ff[k+1] <= y_ff[k] + xs;
            z_ff[k+1] <= z_ff[k] - at;
         end
      end
   end

   always_comb begin
      rnd = z_ff[STEPS] + ANGLE_W'(32768);
      sh  = rnd[ANGLE_W-1:16];
      if (zero_ff[STEPS]) begin
         ang_in = '0;
      end else if (sh > SH_W'(PI_Q13)) begin
         ang_in = PI_Q13;
      end else if (sh < -SH_W'(PI_Q13)) begin
         ang_in = -PI_Q13;
      end else begin
         ang_in = sh[ROLL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else begin
         vout_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
   end

   assign out_valid = vout_ff;
   assign out_angle = ang_ff;

endmodule

@@ sv/quaternion_to_euler.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler: ZYX euler angles from a unit quaternion
// Product sums, pitch square root and three parallel CORDIC pipelines.
// ----------------------------------------------------------------------------
// One quaternion is taken every clock: busy stays low, so a transfer happens
// whenever start is high. Each result appears on the rsp_ ports for one cycle
// with rsp_valid high. On its way it passes the four product stages, the
// 29-stage square root that feeds the pitch arctangent (one root bit per
// stage), the CORDIC pipelines with one rotation per stage and the output
// register. The receiver cannot hold results off; results leave in
// transfer order.
module quaternion_to_euler #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [qte_pkg::QUAT_W-1:0]    req_quat_w,
   input  logic signed [qte_pkg::QUAT_W-1:0]    req_quat_x,
   input  logic signed [qte_pkg::QUAT_W-1:0]    req_quat_y,
   input  logic signed [qte_pkg::QUAT_W-1:0]    req_quat_z,
   output logic                                 rsp_valid,
   output logic signed [qte_pkg::ROLL_W-1:0]    rsp_roll_angle,
   output logic signed [qte_pkg::PITCH_W-1:0]   rsp_pitch_angle,
   output logic signed [qte_pkg::ROLL_W-1:0]    rsp_yaw_angle,
   output logic                                 rsp_pitch_clamped
);
   import qte_pkg::*;

   localparam int CLAT = CORDIC_STEPS + 2;

   logic                     accept;
   logic                     p_valid, s_valid;
   op_type                   p_op, s_op;
   logic [RAD_W-1:0]         p_rad;
   logic [ROOT_W-1:0]        s_root;
   logic signed [PROD_W-1:0] pitch_x;
   logic                     roll_v, pitch_v, yaw_v;
   logic signed [ROLL_W-1:0] roll_a, pitch_a, yaw_a;

   logic                     cl_ff  [0:CLAT-1];
   logic                     neg_ff [0:CLAT-1];

   logic                      valid_ff;
   logic signed [ROLL_W-1:0]  roll_ff, yaw_ff;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic                      clamped_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   qte_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_w      (req_quat_w),
      .in_x      (req_quat_x),
      .in_y      (req_quat_y),
      .in_z      (req_quat_z),
      .out_valid (p_valid),
      .out_op    (p_op),
      .out_rad   (p_rad)
   );

   qte_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_op     (p_op),
      .in_rad    (p_rad),
      .out_valid (s_valid),
      .out_op    (s_op),
      .out_root  (s_root)
   );

   assign pitch_x = PROD_W'(s_root);

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_y      (s_op.roll_y),
      .in_x      (s_op.roll_x),
      .out_valid (roll_v),
      .out_angle (roll_a)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_y      (s_op.pitch_s),
      .in_x      (pitch_x),
      .out_valid (pitch_v),
      .out_angle (pitch_a)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_y      (s_op.yaw_y),
      .in_x      (s_op.yaw_x),
      .out_valid (yaw_v),
      .out_angle (yaw_a)
   );

   // clamp flags ride alongside the cordic pipelines
   always_ff @(posedge clock) begin
      cl_ff[0]  <= s_op.clamp;
      neg_ff[0] <= s_op.neg;
   end

   for (genvar k = 1; k < CLAT; k++) begin : g_flag
      always_ff @(posedge clock) begin
         cl_ff[k]  <= cl_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   always_comb begin
      if (cl_ff[CLAT-1]) begin
         pitch_in = neg_ff[CLAT-1] ? -PITCH_W'(HALF_PI_Q13) : PITCH_W'(HALF_PI_Q13);
      end else if (pitch_a > HALF_PI_Q13) begin
         pitch_in = PITCH_W'(HALF_PI_Q13);
      end else if (pitch_a < -HALF_PI_Q13) begin
         pitch_in = -PITCH_W'(HALF_PI_Q13);
      end else begin
         pitch_in = pitch_a[PITCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pitch_v;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff    <= roll_a;
      yaw_ff     <= yaw_a;
      pitch_ff   <= pitch_in;
      clamped_ff <= cl_ff[CLAT-1];
   end

   assign rsp_valid         = valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_clamped = clamped_ff;

`ifndef SYNTHESIS
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (roll_v == pitch_v) && (yaw_v == pitch_v))
      else $error("cordic lanes out of step");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clamped |->
         (rsp_pitch_angle == PITCH_W'(HALF_PI_Q13)) ||
         (rsp_pitch_angle == -PITCH_W'(HALF_PI_Q13)))
      else $error("clamped pitch not at a pole");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= PI_Q13) && (rsp_roll_angle >= -PI_Q13) &&
         (rsp_yaw_angle <= PI_Q13) && (rsp_yaw_angle >= -PI_Q13))
      else $error("roll or yaw beyond pi");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      pitch_v |=> rsp_valid)
      else $error("result strobe lost");
`endif

endmodule
